/* rtl/lrt_pkg.sv */
package lrt_pkg;

  localparam int ENTRIES    = 64;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int LVLS       = $clog2(ENTRIES);

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_DELETE   = 2'd1,
    KIND_TOUCH    = 2'd2,
    KIND_CONTAINS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] key;
    logic [31:0] value_handle;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic        hit;
    logic        lru_valid;
    logic [15:0] lru_key;
    logic [31:0] lru_value;
    logic [6:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    logic valid;
    logic match;
  } cell_flags_t;

endpackage

/* rtl/lrt_cell.sv */
module lrt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  lrt_pkg::cell_op_t             op,
  input  lrt_pkg::entry_t               prev_ent,
  input  logic                          prev_valid,
  input  lrt_pkg::entry_t               next_ent,
  input  logic                          next_valid,
  input  lrt_pkg::entry_t               load_ent,
  input  logic [lrt_pkg::KEY_BITS-1:0]  probe,
  output lrt_pkg::entry_t               ent,
  output lrt_pkg::cell_flags_t          flags
);
  import lrt_pkg::*;

  logic valid;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD:      ent <= ent;
      CELL_FROM_PREV: ent <= prev_ent;
      CELL_FROM_NEXT: ent <= next_ent;
      CELL_LOAD:      ent <= load_ent;
      default:        ent <= ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (op)
        CELL_HOLD:      valid <= valid;
        CELL_FROM_PREV: valid <= prev_valid;
        CELL_FROM_NEXT: valid <= next_valid;
        CELL_LOAD:      valid <= 1'b1;
        default:        valid <= valid;
      endcase
    end
  end

  assign flags.valid = valid;
  assign flags.match = valid && (ent.key == probe);

endmodule

/* rtl/lrt_onehot_pick.sv */
module lrt_onehot_pick (
  input  logic [lrt_pkg::ENTRIES-1:0] sel,
  input  lrt_pkg::entry_t             ents [lrt_pkg::ENTRIES],
  output lrt_pkg::entry_t             picked
);
  import lrt_pkg::*;

  always_comb begin
    picked = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      picked = picked | (ents[i] & {$bits(entry_t){sel[i]}});
    end
  end

endmodule

/* rtl/lru_recency_table.sv */
// Recency table: a row of cells holds up to ENTRIES key/value words, rank 0 most recent.
// Each request (add, delete, touch, contains) is taken while the block is idle and gives
// one response after these steps in order: one registers every cell's key compare, one moves
// the cells (shift toward the tail on add, close the gap on delete, rotate the touched
// entry to the front), one picks the least recent entry out of the row. The next request
// is taken once the response word has been taken. The response also carries the least
// recent entry and the occupancy for eviction.
module lru_recency_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lrt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lrt_pkg::rsp_t rsp
);
  import lrt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SHIFT, S_REPORT} state_t;

  state_t                 state;
  kind_t                  kind_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [VALUE_BITS-1:0]  value_q;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [ENTRIES-1:0]     match_q;
  logic                   hit_q;
  status_t                status_q;
  status_t                status_next;

  entry_t                 ents [ENTRIES];
  cell_flags_t            flags [ENTRIES];
  cell_op_t               ops [ENTRIES];
  logic [ENTRIES-1:0]     valids;
  logic [ENTRIES-1:0]     match_now;
  logic [ENTRIES-1:0]     last;
  logic [ENTRIES-1:0]     pre [LVLS+1];
  entry_t                 load_ent;
  entry_t                 hit_ent;
  entry_t                 lru_ent;
  logic                   hit;
  logic                   room;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t pe, ne;
    logic   pv, nv;
    if (i == 0) begin : g_head
      assign pe = '0;
      assign pv = 1'b0;
    end else begin : g_mid
      assign pe = ents[i-1];
      assign pv = valids[i-1];
    end
    if (i == ENTRIES - 1) begin : g_tail
      assign ne = '0;
      assign nv = 1'b0;
      assign last[i] = valids[i];
    end else begin : g_body
      assign ne = ents[i+1];
      assign nv = valids[i+1];
      assign last[i] = valids[i] && !valids[i+1];
    end
    lrt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (ops[i]),
      .prev_ent   (pe),
      .prev_valid (pv),
      .next_ent   (ne),
      .next_valid (nv),
      .load_ent   (load_ent),
      .probe      (key_q),
      .ent        (ents[i]),
      .flags      (flags[i])
    );
    assign valids[i]    = flags[i].valid;
    assign match_now[i] = flags[i].match;
  end

  lrt_onehot_pick u_hit_pick (
    .sel    (match_q),
    .ents   (ents),
    .picked (hit_ent)
  );

  lrt_onehot_pick u_lru_pick (
    .sel    (last),
    .ents   (ents),
    .picked (lru_ent)
  );

  // ranks at or past the matching cell
  always_comb begin
    pre[0] = match_q;
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
  end

  assign hit  = |match_q;
  assign room = count < CNT_W'(ENTRIES);
  assign load_ent = (kind_q == KIND_TOUCH) ? hit_ent : entry_t'{key: key_q, value: value_q};

  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    for (int i = 0; i < ENTRIES; i++) begin
      ops[i] = CELL_HOLD;
    end
    unique case (kind_q)
      KIND_ADD: begin
        if (hit) begin
          status_next = ST_DUPLICATE;
        end else if (!room) begin
          status_next = ST_FULL;
        end else if (state == S_SHIFT) begin
          count_next = count + 1'b1;
          for (int i = 0; i < ENTRIES; i++) begin
            ops[i] = (i == 0) ? CELL_LOAD : CELL_FROM_PREV;
          end
        end
      end
      KIND_DELETE: begin
        if (!hit) begin
          status_next = ST_NOT_FOUND;
        end else if (state == S_SHIFT) begin
          count_next = count - 1'b1;
          for (int i = 0; i < ENTRIES; i++) begin
            ops[i] = pre[LVLS][i] ? CELL_FROM_NEXT : CELL_HOLD;
          end
        end
      end
      KIND_TOUCH: begin
        if (!hit) begin
          status_next = ST_NOT_FOUND;
        end else if (state == S_SHIFT) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (i == 0) begin
              ops[i] = CELL_LOAD;
            end else begin
              ops[i] = (!pre[LVLS][i] || match_q[i]) ? CELL_FROM_PREV : CELL_HOLD;
            end
          end
        end
      end
      KIND_CONTAINS: begin
        status_next = ST_OK;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            kind_q  <= req.kind;
            key_q   <= KEY_BITS'(req.key);
            value_q <= VALUE_BITS'(req.value_handle);
            state   <= S_LOOK;
          end
        end
        S_LOOK: begin
          match_q <= match_now;
          state   <= S_SHIFT;
        end
        S_SHIFT: begin
          hit_q    <= hit;
          status_q <= status_next;
          count    <= count_next;
          state    <= S_REPORT;
        end
        S_REPORT: begin
          if (!rsp_valid) begin
            rsp_valid      <= 1'b1;
            rsp.status     <= status_q;
            rsp.hit        <= hit_q;
            rsp.lru_valid  <= (count != '0);
            rsp.lru_key    <= 16'(lru_ent.key);
            rsp.lru_value  <= 32'(lru_ent.value);
            rsp.occupancy  <= 7'(count);
          end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_stall = rst || (state != S_IDLE);

endmodule

/* rtl/lrt_checker.sv */
module lrt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input lrt_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input lrt_pkg::rsp_t rsp
);
  import lrt_pkg::*;

  // a pending response word holds until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // no request taken while a response is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request accepted with response pending");

  // a request taken shows no response in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> !rsp_valid)
    else $error("response too early");

  // empty table reports no lru entry
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (ENTRIES < 128) |->
      ((rsp.occupancy == 7'd0) == !rsp.lru_valid))
    else $error("lru_valid disagrees with occupancy");

  // duplicate implies hit, not found and full imply miss
  a_status_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |->
      ((rsp.status == ST_DUPLICATE) && rsp.hit) ||
      ((rsp.status == ST_NOT_FOUND) && !rsp.hit) ||
      ((rsp.status == ST_FULL) && !rsp.hit) ||
      (rsp.status == ST_OK))
    else $error("status and hit disagree");

endmodule

bind lru_recency_table lrt_checker u_lrt_checker (.*);

/* tb/tb_lru_recency_table.sv */
`timescale 1ns / 1ps

module tb_lru_recency_table;
  import lrt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    req_t word;
    bit   typed;
    rsp_t want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  entry_t    recency[$];
  rsp_t      outcome_q[$];
  step_row_t directed_rows[$];
  rsp_t      want_rsp;
  int        errors = 0;
  int        cycles = 0;
  int        stall_pct = 0;
  int        hold_left = 0;

  lru_recency_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // applies one operation to the recency order, returns the outcome word
  function automatic rsp_t apply_to_recency(req_t w);
    rsp_t   r;
    entry_t e;
    int     rank;
    rank = -1;
    foreach (recency[i]) begin
      if (rank < 0 && recency[i].key == w.key) begin
        rank = i;
      end
    end
    r = '0;
    r.status = ST_OK;
    r.hit = (rank >= 0);
    case (w.kind)
      KIND_ADD: begin
        if (rank >= 0) begin
          r.status = ST_DUPLICATE;
        end else if (recency.size() >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          e.key = w.key;
          e.value = w.value_handle;
          recency.push_front(e);
        end
      end
      KIND_DELETE: begin
        if (rank < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          recency.delete(rank);
        end
      end
      KIND_TOUCH: begin
        if (rank < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          e = recency[rank];
          recency.delete(rank);
          recency.push_front(e);
        end
      end
      default: begin
      end
    endcase
    if (recency.size() > 0) begin
      r.lru_valid = 1'b1;
      r.lru_key = recency[$].key;
      r.lru_value = recency[$].value;
    end
    r.occupancy = 7'(recency.size());
    return r;
  endfunction

  function automatic req_t pick_word(int add_pct, int del_pct, int touch_pct);
    req_t w;
    int   roll;
    roll = $urandom_range(99);
    w.key = 16'($urandom);
    w.value_handle = $urandom;
    if (roll < add_pct) begin
      w.kind = KIND_ADD;
    end else if (roll < add_pct + del_pct) begin
      w.kind = KIND_DELETE;
    end else if (roll < add_pct + del_pct + touch_pct) begin
      w.kind = KIND_TOUCH;
    end else begin
      w.kind = KIND_CONTAINS;
    end
    // mostly aim at keys that are held, adds mostly at fresh keys
    if (recency.size() > 0 && $urandom_range(99) < (w.kind == KIND_ADD ? 15 : 75)) begin
      w.key = recency[$urandom_range(recency.size() - 1)].key;
    end
    return w;
  endfunction

  task automatic plan_step(input kind_t k, input logic [15:0] key, input logic [31:0] val,
                           input bit typed, input status_t st, input bit hit, input bit lv,
                           input logic [15:0] lk, input logic [31:0] lval, input int occ);
    step_row_t s;
    s.word.kind = k;
    s.word.key = key;
    s.word.value_handle = val;
    s.typed = typed;
    s.want.status = st;
    s.want.hit = hit;
    s.want.lru_valid = lv;
    s.want.lru_key = lk;
    s.want.lru_value = lval;
    s.want.occupancy = 7'(occ);
    directed_rows.push_back(s);
  endtask

  task automatic send_word(input req_t w, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
  endtask

  // response side: stall pattern, long hold-off, and checking
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (outcome_q.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) begin
          $display("unexpected word: status=%0d hit=%0b lru_valid=%0b lru_key=%h",
                   rsp.status, rsp.hit, rsp.lru_valid, rsp.lru_key);
        end
      end else begin
        want_rsp = outcome_q.pop_front();
        if (rsp.status !== want_rsp.status || rsp.hit !== want_rsp.hit ||
            rsp.lru_valid !== want_rsp.lru_valid || rsp.lru_key !== want_rsp.lru_key ||
            rsp.lru_value !== want_rsp.lru_value ||
            rsp.occupancy !== want_rsp.occupancy) begin
          errors = errors + 1;
          if (errors <= 10) begin
            $display("mismatch: expected status=%0d hit=%0b lru_valid=%0b lru_key=%h lru_value=%h occ=%0d",
                     want_rsp.status, want_rsp.hit, want_rsp.lru_valid, want_rsp.lru_key,
                     want_rsp.lru_value, want_rsp.occupancy);
            $display("          actual   status=%0d hit=%0b lru_valid=%0b lru_key=%h lru_value=%h occ=%0d",
                     rsp.status, rsp.hit, rsp.lru_valid, rsp.lru_key,
                     rsp.lru_value, rsp.occupancy);
          end
        end
      end
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    rsp_t got;
    req_t w;
    int   idle_pct;
    int   len;
    int   add_pct;
    int   del_pct;
    int   touch_pct;

    // empty table
    plan_step(KIND_CONTAINS, 16'h0000, 32'h00000000, 1, ST_OK, 0, 0, 16'h0, 32'h0, 0);
    plan_step(KIND_DELETE, 16'hFFFF, 32'hFFFFFFFF, 1, ST_NOT_FOUND, 0, 0, 16'h0, 32'h0, 0);
    plan_step(KIND_TOUCH, 16'h1234, 32'h0000BEEF, 1, ST_NOT_FOUND, 0, 0, 16'h0, 32'h0, 0);
    // extremes, duplicate, touch at front and at tail
    plan_step(KIND_ADD, 16'h0000, 32'h00000000, 1, ST_OK, 0, 1, 16'h0000, 32'h0, 1);
    plan_step(KIND_ADD, 16'hFFFF, 32'hFFFFFFFF, 1, ST_OK, 0, 1, 16'h0000, 32'h0, 2);
    plan_step(KIND_ADD, 16'h0000, 32'h12345678, 1, ST_DUPLICATE, 1, 1, 16'h0000, 32'h0, 2);
    plan_step(KIND_TOUCH, 16'hFFFF, 32'h0, 1, ST_OK, 1, 1, 16'h0000, 32'h0, 2);
    plan_step(KIND_TOUCH, 16'h0000, 32'h0, 1, ST_OK, 1, 1, 16'hFFFF, 32'hFFFFFFFF, 2);
    plan_step(KIND_CONTAINS, 16'hFFFF, 32'h0, 1, ST_OK, 1, 1, 16'hFFFF, 32'hFFFFFFFF, 2);
    plan_step(KIND_CONTAINS, 16'h8000, 32'h0, 1, ST_OK, 0, 1, 16'hFFFF, 32'hFFFFFFFF, 2);
    plan_step(KIND_DELETE, 16'h1234, 32'h0, 1, ST_NOT_FOUND, 0, 1, 16'hFFFF, 32'hFFFFFFFF, 2);
    plan_step(KIND_DELETE, 16'hFFFF, 32'h0, 1, ST_OK, 1, 1, 16'h0000, 32'h0, 1);
    plan_step(KIND_DELETE, 16'h0000, 32'h0, 1, ST_OK, 1, 0, 16'h0, 32'h0, 0);
    // tail touch and tail delete
    plan_step(KIND_ADD, 16'h5555, 32'hAAAAAAAA, 0, ST_OK, 0, 0, 16'h0, 32'h0, 0);
    plan_step(KIND_ADD, 16'hAAAA, 32'h55555555, 0, ST_OK, 0, 0, 16'h0, 32'h0, 0);
    plan_step(KIND_ADD, 16'h0F0F, 32'hF0F0F0F0, 0, ST_OK, 0, 0, 16'h0, 32'h0, 0);
    plan_step(KIND_TOUCH, 16'h5555, 32'h13579BDF, 0, ST_OK, 0, 0, 16'h0, 32'h0, 0);
    plan_step(KIND_DELETE, 16'hAAAA, 32'h2468ACE0, 0, ST_OK, 0, 0, 16'h0, 32'h0, 0);
    plan_step(KIND_CONTAINS, 16'h0F0F, 32'hFFFFFFFF, 0, ST_OK, 0, 0, 16'h0, 32'h0, 0);
    plan_step(KIND_ADD, 16'h5555, 32'h01234567, 0, ST_OK, 0, 0, 16'h0, 32'h0, 0);
    plan_step(KIND_DELETE, 16'h0F0F, 32'h0, 0, ST_OK, 0, 0, 16'h0, 32'h0, 0);
    plan_step(KIND_DELETE, 16'h5555, 32'h0, 0, ST_OK, 0, 0, 16'h0, 32'h0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, 0);
      got = apply_to_recency(directed_rows[i].word);
      outcome_q.push_back(directed_rows[i].typed ? directed_rows[i].want : got);
    end
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin  // fill to full, no idling
          idle_pct = 0;  stall_pct = 0;  len = 110;
          add_pct = 85;  del_pct = 5;   touch_pct = 5;
        end
        1: begin
          idle_pct = 86; stall_pct = 0;  len = 80;
          add_pct = 25;  del_pct = 25;  touch_pct = 25;
        end
        2: begin
          idle_pct = 0;  stall_pct = 86; len = 80;
          add_pct = 40;  del_pct = 20;  touch_pct = 20;
        end
        3: begin  // drain to empty
          idle_pct = 11; stall_pct = 11; len = 100;
          add_pct = 10;  del_pct = 70;  touch_pct = 10;
        end
        default: begin  // long receiver hold-off while words keep coming
          idle_pct = 0;  stall_pct = 0;  len = 80;
          add_pct = 40;  del_pct = 20;  touch_pct = 20;
          hold_left = 300;
        end
      endcase
      for (int n = 0; n < len; n++) begin
        w = pick_word(add_pct, del_pct, touch_pct);
        send_word(w, idle_pct);
        outcome_q.push_back(apply_to_recency(w));
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
